// File: sv/sglp_pkg.sv
// shared constants and helpers for the ssh greeting line parser
`default_nettype none

package sglp_pkg;

    localparam int unsigned LimitWidth    = 10;
    localparam int unsigned ColWidth      = 11;
    localparam int unsigned VerWidth      = 16;
    localparam int unsigned OutDataWidth  = 40;

    localparam logic [LimitWidth-1:0] LIMIT_RESET = 10'd255;
    localparam logic [ColWidth-1:0]   COL_MAX     = 11'd2047;
    localparam logic [VerWidth-1:0]   VER_MAX     = 16'hFFFF;

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // prefix match phases: 0..3 bytes of "SSH-" matched so far
    localparam logic [2:0] PH_GREETING = 3'd4;
    localparam logic [2:0] PH_OTHER    = 3'd5;

    // version parse phases
    localparam logic [1:0] VP_MAJOR = 2'd0;
    localparam logic [1:0] VP_MINOR = 2'd1;
    localparam logic [1:0] VP_DASH  = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_CR_NO_LF     = 3'd1;
    localparam logic [2:0] ST_DUPLICATE    = 3'd2;
    localparam logic [2:0] ST_NO_DASH      = 3'd3;
    localparam logic [2:0] ST_UNTERMINATED = 3'd4;

    // expected byte of "SSH-" at a given match position
    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h53;
            2'd1:    c = 8'h53;
            2'd2:    c = 8'h48;
            default: c = CHAR_DASH;
        endcase
        return c;
    endfunction

    // acc * 10 + digit, saturating at the version maximum
    function automatic logic [VerWidth-1:0] add_digit(input logic [VerWidth-1:0] acc,
                                                      input logic [3:0] digit);
        logic [VerWidth+3:0] sum;
        sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{VerWidth{1'b0}}, digit};
        return (sum > {4'd0, VER_MAX}) ? VER_MAX : sum[VerWidth-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/ssh_greeting_line_parser.sv
// top level: byte stream splitter and ssh identification line parser
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata = data_byte, s_tlast = last_byte
//  m_        out  m_tvalid/m_tready  m_tdata = status and version fields
//  cfg_      in   cfg_wr_en          cfg_wr_data = greeting_length_limit
//
// one byte per cycle; the line state registers update on each input transfer
// and a status transfer is loaded into the output register on the last byte,
// so it shows on m_ the cycle after that byte is taken
// the output register decouples the sides: a byte is taken whenever the
// output register is empty or is being drained in the same cycle
// any byte waits while a status is held and m_tready is low
// aresetn is synchronous, active low; it clears the line and buffer state and
// the output valid flag and restores the length limit to 255
`default_nettype none

module ssh_greeting_line_parser
    import sglp_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // input byte stream
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [7:0]              s_tdata,   // [7:0] data_byte
    input  wire logic                    s_tlast,   // last_byte
    // status stream
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // [2:0] status_code, [3] greeting_found, [4] greeting_too_long,
    // [20:5] version_major, [36:21] version_minor, [39:37] zero
    output logic [OutDataWidth-1:0]      m_tdata,
    // length limit register
    input  wire logic                    cfg_wr_en,
    input  wire logic [LimitWidth-1:0]   cfg_wr_data
);

    // configuration
    logic [LimitWidth-1:0] limit_reg;

    // per line state
    logic [ColWidth-1:0]   col_reg,      col_next;
    logic [2:0]            prefix_reg,   prefix_next;
    logic [1:0]            vphase_reg,   vphase_next;
    logic [VerWidth-1:0]   major_reg,    major_next;
    logic [VerWidth-1:0]   minor_reg,    minor_next;
    logic                  cr_reg,       cr_next;
    logic                  stopped_reg,  stopped_next;

    // per buffer state
    logic                  found_reg,    found_next;
    logic                  too_long_reg, too_long_next;
    logic [2:0]            err_reg,      err_next;
    logic [VerWidth-1:0]   kmajor_reg,   kmajor_next;
    logic [VerWidth-1:0]   kminor_reg,   kminor_next;

    // output register
    logic                    m_valid_reg;
    logic [OutDataWidth-1:0] m_data_reg;
    logic [OutDataWidth-1:0] m_data_next;

    logic s_xfer;
    logic line_end;
    logic line_byte;
    logic is_digit;
    logic [2:0] final_err;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign is_digit = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);

    // classify the byte: line ending or line content
    always_comb begin
        line_end  = 1'b0;
        line_byte = 1'b0;
        if (err_reg == ST_OK) begin
            if (cr_reg) begin
                line_end = (s_tdata == CHAR_LF);
            end else if (s_tdata == CHAR_LF) begin
                line_end = 1'b1;
            end else if (s_tdata != CHAR_CR) begin
                line_byte = 1'b1;
            end
        end
    end

    always_comb begin
        col_next      = col_reg;
        prefix_next   = prefix_reg;
        vphase_next   = vphase_reg;
        major_next    = major_reg;
        minor_next    = minor_reg;
        cr_next       = cr_reg;
        stopped_next  = stopped_reg;
        found_next    = found_reg;
        too_long_next = too_long_reg;
        err_next      = err_reg;
        kmajor_next   = kmajor_reg;
        kminor_next   = kminor_reg;
        final_err     = err_reg;
        m_data_next   = m_data_reg;

        if (s_xfer) begin
            // cr followed by something other than lf
            if (err_reg == ST_OK && cr_reg && s_tdata != CHAR_LF) begin
                err_next = ST_CR_NO_LF;
            end
            if (err_reg == ST_OK && !cr_reg && s_tdata == CHAR_CR) begin
                cr_next = 1'b1;
            end

            if (line_byte) begin
                if (col_reg != COL_MAX) begin
                    col_next = col_reg + ColWidth'(1);
                end
                if (prefix_reg < PH_GREETING) begin
                    prefix_next = (s_tdata == prefix_char(prefix_reg[1:0]))
                                  ? prefix_reg + 3'd1 : PH_OTHER;
                end else if (prefix_reg == PH_GREETING && vphase_reg != VP_DASH) begin
                    // version text up to the dash
                    if (s_tdata == CHAR_DASH) begin
                        vphase_next = VP_DASH;
                    end else if (vphase_reg == VP_MAJOR && s_tdata == CHAR_DOT) begin
                        vphase_next  = VP_MINOR;
                        stopped_next = 1'b0;
                    end else if (!stopped_reg) begin
                        if (!is_digit) begin
                            stopped_next = 1'b1;
                        end else if (vphase_reg == VP_MAJOR) begin
                            major_next = add_digit(major_reg, s_tdata[3:0]);
                        end else begin
                            minor_next = add_digit(minor_reg, s_tdata[3:0]);
                        end
                    end
                end
            end

            if (line_end) begin
                if (prefix_reg == PH_GREETING) begin
                    if (found_reg) begin
                        err_next = ST_DUPLICATE;
                    end else begin
                        found_next = 1'b1;
                        if (col_reg >= {1'b0, limit_reg}) begin
                            too_long_next = 1'b1;
                        end else if (vphase_reg != VP_DASH) begin
                            err_next = ST_NO_DASH;
                        end else begin
                            kmajor_next = major_reg;
                            kminor_next = minor_reg;
                        end
                    end
                end
                col_next     = '0;
                prefix_next  = '0;
                vphase_next  = VP_MAJOR;
                major_next   = '0;
                minor_next   = '0;
                cr_next      = 1'b0;
                stopped_next = 1'b0;
            end

            // end of buffer: close out status, then clear everything
            final_err = err_next;
            if (s_tlast) begin
                if (err_next == ST_OK) begin
                    if (cr_next) begin
                        final_err = ST_CR_NO_LF;
                    end else if (col_next != '0) begin
                        final_err = ST_UNTERMINATED;
                    end
                end
                // status word, taken from values as they stand after this byte
                m_data_next = {3'd0, kminor_next, kmajor_next,
                               too_long_next, found_next, final_err};
                col_next      = '0;
                prefix_next   = '0;
                vphase_next   = VP_MAJOR;
                major_next    = '0;
                minor_next    = '0;
                cr_next       = 1'b0;
                stopped_next  = 1'b0;
                found_next    = 1'b0;
                too_long_next = 1'b0;
                err_next      = ST_OK;
                kmajor_next   = '0;
                kminor_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= LIMIT_RESET;
            col_reg      <= '0;
            prefix_reg   <= '0;
            vphase_reg   <= VP_MAJOR;
            major_reg    <= '0;
            minor_reg    <= '0;
            cr_reg       <= 1'b0;
            stopped_reg  <= 1'b0;
            found_reg    <= 1'b0;
            too_long_reg <= 1'b0;
            err_reg      <= ST_OK;
            kmajor_reg   <= '0;
            kminor_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            col_reg      <= col_next;
            prefix_reg   <= prefix_next;
            vphase_reg   <= vphase_next;
            major_reg    <= major_next;
            minor_reg    <= minor_next;
            cr_reg       <= cr_next;
            stopped_reg  <= stopped_next;
            found_reg    <= found_next;
            too_long_reg <= too_long_next;
            err_reg      <= err_next;
            kmajor_reg   <= kmajor_next;
            kminor_reg   <= kminor_next;
            // status transfer on the last byte, otherwise drain
            if (s_xfer && s_tlast) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // status payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_xfer && s_tlast) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire
